// File: design/epoch_reclaim_tracker_top_macros.svh
// Assertion macros for the epoch reclaim tracker.
// Included by the top level only; no dependencies.
`ifndef EPOCH_RECLAIM_TRACKER_TOP_MACROS_SVH
`define EPOCH_RECLAIM_TRACKER_TOP_MACROS_SVH
`define ERT_ASSERT_IMPL(label, clk, rst_n, a, c, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error(msg);
`define ERT_ASSERT_NEXT(label, clk, rst_n, a, c, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error(msg);
`endif

// File: design/ert_pkg.sv
// Shared types and codes for the epoch reclaim tracker.
// No dependencies.
package ert_pkg;
	localparam logic [1:0] ACT_ENTER  = 2'd0;
	localparam logic [1:0] ACT_EXIT   = 2'd1;
	localparam logic [1:0] ACT_RETIRE = 2'd2;
	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_NULL    = 2'd1;
	localparam logic [1:0] ST_FULL    = 2'd2;
	localparam logic [1:0] ST_UNDER   = 2'd3;

	typedef struct packed {
		logic [1:0]  action;
		logic [2:0]  cpu;
		logic [31:0] ref_handle;
		logic [31:0] free_routine;
	} req_t;

	typedef struct packed {
		logic        kind;
		logic [31:0] freed_handle;
		logic [31:0] freed_routine;
		logic [1:0]  status;
		logic [4:0]  live_count;
		logic [4:0]  peak_count;
		logic        last;
	} rsp_t;

	// controller -> datapath
	typedef struct packed {
		logic load;      // capture request
		logic upd;       // apply enter/exit update
		logic scan_clr;  // start safe-epoch scan
		logic scan_step; // fold one cpu into safe
		logic slot_clr;  // restart slot index
		logic slot_rd;   // issue slot read
		logic free_slot; // release current slot, emit freed item
		logic store;     // store retire in first free slot
		logic done_emit; // emit completion
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic [1:0] action;
		logic       null_ret;
		logic       outer_exit;
		logic       scan_end;
		logic       slot_end;
		logic       slot_hit;
	} sts_t;
endpackage

// File: design/ert_if.sv
// Valid/ready channel carrying one payload type.
// Uses nothing; payload type given by parameter.
interface ert_if #(parameter type T = logic) ();
	logic valid;
	logic ready;
	T     data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// File: design/ert_ctrl.sv
// Controller FSM: sequences enter/exit, safe-epoch scan, reclaim and retire store.
// Depends on ert_pkg.
module ert_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic          out_busy,
	input  ert_pkg::sts_t sts,
	output ert_pkg::cmd_t cmd
);
	typedef enum logic [7:0] {
		S_IDLE = 8'b0000_0001,
		S_UPD  = 8'b0000_0010,
		S_SCAN = 8'b0000_0100,
		S_RD   = 8'b0000_1000,
		S_CHK  = 8'b0001_0000,
		S_SRD  = 8'b0010_0000,
		S_SCHK = 8'b0100_0000,
		S_DONE = 8'b1000_0000
	} state_t;
	state_t state_q, nxt;

	always_comb begin
		nxt = state_q;
		cmd = '0;
		in_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					nxt = S_UPD;
				end
			end
			S_UPD: begin
				cmd.upd = 1'b1;
				cmd.scan_clr = 1'b1;
				if ((sts.action == ert_pkg::ACT_EXIT && sts.outer_exit) ||
				    (sts.action == ert_pkg::ACT_RETIRE && !sts.null_ret))
					nxt = S_SCAN;
				else
					nxt = S_DONE;
			end
			S_SCAN: begin
				cmd.scan_step = 1'b1;
				if (sts.scan_end) begin
					cmd.slot_clr = 1'b1;
					nxt = S_RD;
				end
			end
			S_RD: begin
				if (sts.slot_end) begin
					cmd.slot_clr = 1'b1;
					nxt = (sts.action == ert_pkg::ACT_RETIRE) ? S_SRD : S_DONE;
				end else begin
					cmd.slot_rd = 1'b1;
					nxt = S_CHK;
				end
			end
			S_CHK: begin
				if (sts.slot_hit) begin
					if (!out_busy) begin
						cmd.free_slot = 1'b1;
						nxt = S_RD;
					end
				end else begin
					nxt = S_RD;
				end
			end
			S_SRD: begin
				cmd.store = 1'b1;
				nxt = S_DONE;
			end
			S_DONE: begin
				if (!out_busy) begin
					cmd.done_emit = 1'b1;
					nxt = S_IDLE;
				end
			end
			default: nxt = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= nxt;
	end
endmodule

// File: design/ert_dp.sv
// Datapath: per-cpu state, slot table memory, safe-epoch scan, output register.
// Depends on ert_pkg.
module ert_dp #(
	parameter int MAX_CPUS = 8,
	parameter int RETIRE_SLOTS = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_we,
	input  logic [3:0]    cfg_data,
	input  ert_pkg::req_t req,
	input  ert_pkg::cmd_t cmd,
	output ert_pkg::sts_t sts,
	output logic          out_valid,
	input  logic          out_ready,
	output ert_pkg::rsp_t out_data
);
	localparam int CW = (MAX_CPUS > 1) ? $clog2(MAX_CPUS) : 1;
	localparam int SW = (RETIRE_SLOTS > 1) ? $clog2(RETIRE_SLOTS) : 1;
	localparam int TS = MAX_CPUS * RETIRE_SLOTS;
	localparam int AW = (TS > 1) ? $clog2(TS) : 1;
	localparam int NW = $clog2(MAX_CPUS + 1);

	logic [3:0]  ciu_q;
	logic [31:0] gep_q;
	logic [7:0]  depth_q [MAX_CPUS];
	logic        act_q [MAX_CPUS];
	logic [31:0] lep_q [MAX_CPUS];
	logic [4:0]  live_q [MAX_CPUS];
	logic [4:0]  peak_q [MAX_CPUS];
	logic [TS-1:0] used_q;
	logic [95:0] mem [TS];
	logic [95:0] rd_q;
	logic [1:0]  act_r_q;
	logic [CW-1:0] cpu_q;
	logic [31:0] h_q, r_q, safe_q;
	logic [1:0]  st_q;
	logic [NW-1:0] scan_q;
	logic [SW:0] slot_q;
	logic [AW-1:0] addr_q;
	logic [CW-1:0] rc;
	logic [31:0] cpu_m;
	logic [NW-1:0] ncpu;
	logic [AW-1:0] base, sa;
	logic [SW-1:0] free_idx;
	logic        free_ok;

	// cpu modulo MAX_CPUS by repeated subtract, cpu is only 3 bits
	always_comb begin
		cpu_m = 32'(req.cpu);
		for (int k = 0; k < 8; k++)
			if (cpu_m >= 32'(MAX_CPUS)) cpu_m = cpu_m - 32'(MAX_CPUS);
		rc = CW'(cpu_m);
	end
	always_comb begin
		if (ciu_q == 4'd0) ncpu = NW'(1);
		else if (32'(ciu_q) > 32'(MAX_CPUS)) ncpu = NW'(MAX_CPUS);
		else ncpu = NW'(ciu_q);
	end
	assign base = AW'(32'(cpu_q) * 32'(RETIRE_SLOTS));
	assign sa = base + AW'(slot_q[SW-1:0]);

	always_comb begin
		free_idx = '0;
		free_ok = 1'b0;
		for (int i = RETIRE_SLOTS - 1; i >= 0; i--) begin
			if (!used_q[base + AW'(i)]) begin
				free_idx = SW'(i);
				free_ok = 1'b1;
			end
		end
	end

	assign sts.action = act_r_q;
	assign sts.null_ret = (h_q == 32'd0) || (r_q == 32'd0);
	assign sts.outer_exit = (depth_q[cpu_q] == 8'd1);
	assign sts.scan_end = (scan_q >= ncpu - NW'(1));
	assign sts.slot_end = (slot_q == (SW+1)'(RETIRE_SLOTS));
	assign sts.slot_hit = used_q[addr_q] && (rd_q[31:0] < safe_q);

	always_ff @(posedge clk) begin
		if (cmd.slot_rd) rd_q <= mem[sa];
		if (cmd.store && free_ok)
			mem[base + AW'(free_idx)] <= {h_q, r_q, gep_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ciu_q <= 4'd8;
			gep_q <= 32'd1;
			used_q <= '0;
			act_r_q <= '0;
			cpu_q <= '0;
			h_q <= '0;
			r_q <= '0;
			safe_q <= '0;
			st_q <= '0;
			scan_q <= '0;
			slot_q <= '0;
			addr_q <= '0;
			out_valid <= 1'b0;
			out_data <= '0;
			for (int i = 0; i < MAX_CPUS; i++) begin
				depth_q[i] <= '0;
				act_q[i] <= 1'b0;
				lep_q[i] <= '0;
				live_q[i] <= '0;
				peak_q[i] <= '0;
			end
		end else begin
			if (cfg_we) ciu_q <= cfg_data;
			if (cmd.free_slot || cmd.done_emit) out_valid <= 1'b1;
			else if (out_ready) out_valid <= 1'b0;
			if (cmd.load) begin
				act_r_q <= req.action;
				cpu_q <= rc;
				h_q <= req.ref_handle;
				r_q <= req.free_routine;
				st_q <= ert_pkg::ST_OK;
			end
			if (cmd.upd) begin
				case (act_r_q)
					ert_pkg::ACT_ENTER: begin
						if (depth_q[cpu_q] == 8'd0) begin
							lep_q[cpu_q] <= gep_q;
							act_q[cpu_q] <= 1'b1;
						end
						if (depth_q[cpu_q] != 8'hFF) depth_q[cpu_q] <= depth_q[cpu_q] + 8'd1;
					end
					ert_pkg::ACT_EXIT: begin
						if (depth_q[cpu_q] == 8'd0) st_q <= ert_pkg::ST_UNDER;
						else begin
							depth_q[cpu_q] <= depth_q[cpu_q] - 8'd1;
							if (depth_q[cpu_q] == 8'd1) begin
								act_q[cpu_q] <= 1'b0;
								if (gep_q != 32'hFFFF_FFFF) gep_q <= gep_q + 32'd1;
							end
						end
					end
					ert_pkg::ACT_RETIRE: begin
						if (h_q == 32'd0 || r_q == 32'd0) st_q <= ert_pkg::ST_NULL;
					end
					default: ;
				endcase
			end
			if (cmd.scan_clr) begin
				scan_q <= '0;
				safe_q <= (act_r_q == ert_pkg::ACT_EXIT && depth_q[cpu_q] == 8'd1 &&
				    gep_q != 32'hFFFF_FFFF) ? gep_q + 32'd1 : gep_q;
			end
			if (cmd.scan_step) begin
				if (act_q[scan_q[CW-1:0]] && lep_q[scan_q[CW-1:0]] < safe_q)
					safe_q <= lep_q[scan_q[CW-1:0]];
				scan_q <= scan_q + NW'(1);
			end
			if (cmd.slot_clr) slot_q <= '0;
			if (cmd.slot_rd) begin
				addr_q <= sa;
				slot_q <= slot_q + (SW+1)'(1);
			end
			if (cmd.free_slot) begin
				used_q[addr_q] <= 1'b0;
				if (live_q[cpu_q] != 5'd0) live_q[cpu_q] <= live_q[cpu_q] - 5'd1;
				out_data <= '{kind: 1'b0, freed_handle: rd_q[95:64],
					freed_routine: rd_q[63:32], status: ert_pkg::ST_OK,
					live_count: 5'd0, peak_count: 5'd0, last: 1'b0};
			end
			if (cmd.store) begin
				if (free_ok) begin
					used_q[base + AW'(free_idx)] <= 1'b1;
					live_q[cpu_q] <= live_q[cpu_q] + 5'd1;
					if (live_q[cpu_q] + 5'd1 > peak_q[cpu_q])
						peak_q[cpu_q] <= live_q[cpu_q] + 5'd1;
				end else st_q <= ert_pkg::ST_FULL;
			end
			if (cmd.done_emit) begin
				out_data <= '{kind: 1'b1, freed_handle: 32'd0, freed_routine: 32'd0,
					status: st_q, live_count: live_q[cpu_q],
					peak_count: peak_q[cpu_q], last: 1'b1};
			end
		end
	end
endmodule

// File: design/epoch_reclaim_tracker_top.sv
// Epoch reclaim tracker top. A request without reclaim goes accept, update, done; the
// registered completion waits while a result holds. Reclaiming requests add the scan
// of the configured cpus, a read and check of each cpu slot, and a store for a retire.
// One request at a time: a new request is taken only in idle.
// arst_n clears epochs, depths, used bits and counts; global epoch resets to 1.
// Depends on ert_pkg, ert_if, ert_ctrl, ert_dp and the macros header.
`include "epoch_reclaim_tracker_top_macros.svh"
module epoch_reclaim_tracker_top #(
	parameter int MAX_CPUS = 8,
	parameter int RETIRE_SLOTS = 16
) (
	input logic       clk,
	input logic       arst_n,
	input logic       cfg_we,
	input logic [3:0] cfg_data,
	ert_if.sink       req,
	ert_if.source     rsp
);
	ert_pkg::cmd_t cmd;
	ert_pkg::sts_t sts;
	logic busy;

	assign busy = rsp.valid && !rsp.ready;

	ert_ctrl u_ctrl (.clk, .arst_n, .in_valid(req.valid), .in_ready(req.ready),
		.out_busy(busy), .sts, .cmd);
	ert_dp #(.MAX_CPUS(MAX_CPUS), .RETIRE_SLOTS(RETIRE_SLOTS)) u_dp (.clk, .arst_n,
		.cfg_we, .cfg_data, .req(req.data), .cmd, .sts, .out_valid(rsp.valid),
		.out_ready(rsp.ready), .out_data(rsp.data));

	`ERT_ASSERT_IMPL(a_last_kind, clk, arst_n, rsp.valid, rsp.data.last == rsp.data.kind, "bad last")
	`ERT_ASSERT_NEXT(a_accept_busy, clk, arst_n, req.valid && req.ready, !req.ready, "accepted while busy")
endmodule
